// ===== design/nte_pkg.sv =====
// ----------------------------------------------------------------------------
// nte_pkg: shared definitions for the NMEA time and date extractor
// Widths, character codes, the zone offset table and the structs that pass
// between the parser, the clock arithmetic and the result register.
// ----------------------------------------------------------------------------
package nte_pkg;

   // sentence framing limits
   localparam int MAX_FIELDS  = 15;
   localparam int FIELD_W     = $clog2(MAX_FIELDS + 1);
   localparam int PREFIX_LEN  = 6;
   localparam int DIGIT_COUNT = 6;
   localparam int GGA_TIME_FIELD = 1;
   localparam int RMC_DATE_FIELD = 9;

   // zone selection
   localparam int ZONE_COUNT = 38;
   localparam int ZONE_W     = 6;
   localparam logic [ZONE_W-1:0] ZONE_RESET = 6'd14;

   // channel widths
   localparam int BYTE_W     = 8;
   localparam int CODE_W     = 4;
   localparam int RSP_DATA_W = 40;

   // special characters
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

   // stored character classes (digits keep their value)
   localparam logic [CODE_W-1:0] CODE_SPACE = 4'd10;
   localparam logic [CODE_W-1:0] CODE_PLUS  = 4'd11;
   localparam logic [CODE_W-1:0] CODE_MINUS = 4'd12;
   localparam logic [CODE_W-1:0] CODE_OTHER = 4'd15;

   // what the parser hands on when a sentence ends
   typedef struct packed {
      logic                                  emit;
      logic                                  is_rmc;
      logic                                  time_upd;
      logic                                  date_upd;
      logic [DIGIT_COUNT-1:0][CODE_W-1:0]    digits;
   } nte_capture_type;

   // decoded time and date ready to be held
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [6:0] year;
      logic [6:0] month;
      logic [6:0] day;
   } nte_values_type;

   // zone offset split into floor hours and remaining minutes
   typedef struct packed {
      logic signed [4:0] hour;
      logic [5:0]        minute;
   } nte_zone_type;

   function automatic nte_zone_type zone_offset(input logic [ZONE_W-1:0] idx);
      nte_zone_type r;
      r = '0;
      unique case (idx)
         6'd0:    r = '{-5'sd12, 6'd0};
         6'd1:    r = '{-5'sd11, 6'd0};
         6'd2:    r = '{-5'sd10, 6'd0};
         6'd3:    r = '{-5'sd10, 6'd30};
         6'd4:    r = '{-5'sd9,  6'd0};
         6'd5:    r = '{-5'sd8,  6'd0};
         6'd6:    r = '{-5'sd7,  6'd0};
         6'd7:    r = '{-5'sd6,  6'd0};
         6'd8:    r = '{-5'sd5,  6'd0};
         6'd9:    r = '{-5'sd4,  6'd0};
         6'd10:   r = '{-5'sd4,  6'd30};
         6'd11:   r = '{-5'sd3,  6'd0};
         6'd12:   r = '{-5'sd2,  6'd0};
         6'd13:   r = '{-5'sd1,  6'd0};
         6'd14:   r = '{5'sd0,   6'd0};
         6'd15:   r = '{5'sd1,   6'd0};
         6'd16:   r = '{5'sd2,   6'd0};
         6'd17:   r = '{5'sd3,   6'd0};
         6'd18:   r = '{5'sd3,   6'd30};
         6'd19:   r = '{5'sd4,   6'd0};
         6'd20:   r = '{5'sd4,   6'd30};
         6'd21:   r = '{5'sd5,   6'd0};
         6'd22:   r = '{5'sd5,   6'd30};
         6'd23:   r = '{5'sd5,   6'd45};
         6'd24:   r = '{5'sd6,   6'd0};
         6'd25:   r = '{5'sd6,   6'd30};
         6'd26:   r = '{5'sd7,   6'd0};
         6'd27:   r = '{5'sd8,   6'd0};
         6'd28:   r = '{5'sd8,   6'd45};
         6'd29:   r = '{5'sd9,   6'd0};
         6'd30:   r = '{5'sd9,   6'd30};
         6'd31:   r = '{5'sd10,  6'd0};
         6'd32:   r = '{5'sd10,  6'd30};
         6'd33:   r = '{5'sd11,  6'd0};
         6'd34:   r = '{5'sd12,  6'd0};
         6'd35:   r = '{5'sd12,  6'd45};
         6'd36:   r = '{5'sd13,  6'd0};
         6'd37:   r = '{5'sd14,  6'd0};
         default: r = '{5'sd0,   6'd0};
      endcase
      return r;
   endfunction

endpackage

// ===== design/nte_parser.sv =====
// ----------------------------------------------------------------------------
// nte_parser: sentence tracker
// Matches the six character prefix, counts comma separated fields and keeps
// the first six character codes of the time or date field.
// ----------------------------------------------------------------------------
module nte_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [nte_pkg::BYTE_W-1:0]    byte_in,
   output nte_pkg::nte_capture_type      capture
);

   localparam logic [nte_pkg::FIELD_W-1:0] FIELD_LAST = nte_pkg::FIELD_W'(nte_pkg::MAX_FIELDS);
   localparam logic [nte_pkg::FIELD_W-1:0] FIELD_GGA  =
      nte_pkg::FIELD_W'(nte_pkg::GGA_TIME_FIELD);
   localparam logic [nte_pkg::FIELD_W-1:0] FIELD_RMC  =
      nte_pkg::FIELD_W'(nte_pkg::RMC_DATE_FIELD);

   logic [2:0]                    pos_ff, pos_in;
   logic                          gga_ff, gga_in;
   logic                          rmc_ff, rmc_in;
   logic [nte_pkg::FIELD_W-1:0]   field_ff, field_in;
   logic [2:0]                    count_ff, count_in;
   logic [nte_pkg::DIGIT_COUNT-1:0][nte_pkg::CODE_W-1:0] digits_ff, digits_in;
   logic                          pend_ff, pend_in;
   logic                          done;
   logic                          in_target;

   // expected prefix character for either sentence type
   function automatic logic [nte_pkg::BYTE_W-1:0] prefix_char(input logic rmc,
                                                              input logic [2:0] pos);
      logic [nte_pkg::BYTE_W-1:0] c;
      c = 8'h00;
      unique case (pos)
         3'd0:    c = 8'h24;
         3'd1:    c = 8'h47;
         3'd2:    c = 8'h50;
         3'd3:    c = rmc ? 8'h52 : 8'h47;
         3'd4:    c = rmc ? 8'h4D : 8'h47;
         3'd5:    c = rmc ? 8'h43 : 8'h41;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // character class as stored for the pair reader
   function automatic logic [nte_pkg::CODE_W-1:0] char_code(input logic [nte_pkg::BYTE_W-1:0] c);
      logic [nte_pkg::CODE_W-1:0] k;
      k = nte_pkg::CODE_OTHER;
      if (c >= 8'h30 && c <= 8'h39) begin
         k = 4'(c - 8'h30);
      end else if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
         k = nte_pkg::CODE_SPACE;
      end else if (c == 8'h2B) begin
         k = nte_pkg::CODE_PLUS;
      end else if (c == 8'h2D) begin
         k = nte_pkg::CODE_MINUS;
      end
      return k;
   endfunction

   // next sentence state and capture for the byte in the input register
   always_comb begin
      pos_in    = pos_ff;
      gga_in    = gga_ff;
      rmc_in    = rmc_ff;
      field_in  = field_ff;
      count_in  = count_ff;
      digits_in = digits_ff;
      pend_in   = pend_ff;
      in_target = 1'b0;
      done      = (pos_ff >= 3'(nte_pkg::PREFIX_LEN)) && (gga_ff || rmc_ff);
      capture        = '0;
      capture.digits = digits_ff;
      capture.is_rmc = !gga_ff;
      if (byte_in != nte_pkg::CHAR_CR) begin
         if (byte_in == nte_pkg::CHAR_LF) begin
            // end of sentence: report and start over
            capture.emit     = step && done;
            capture.time_upd = step && done && pend_ff && gga_ff;
            capture.date_upd = step && done && pend_ff && !gga_ff;
            pos_in   = '0;
            gga_in   = 1'b1;
            rmc_in   = 1'b1;
            field_in = '0;
            count_in = '0;
            pend_in  = 1'b0;
         end else begin
            // prefix compare on the first six characters
            if (pos_ff < 3'(nte_pkg::PREFIX_LEN)) begin
               if (byte_in != prefix_char(1'b0, pos_ff)) begin
                  gga_in = 1'b0;
               end
               if (byte_in != prefix_char(1'b1, pos_ff)) begin
                  rmc_in = 1'b0;
               end
               pos_in = pos_ff + 3'd1;
            end
            in_target = (gga_in && !rmc_in && field_ff == FIELD_GGA) ||
                        (rmc_in && !gga_in && field_ff == FIELD_RMC);
            if (byte_in == nte_pkg::CHAR_COMMA) begin
               // a comma closes the field
               if (in_target && field_ff < FIELD_LAST) begin
                  pend_in = gga_in ? (count_ff >= 3'd6) : (count_ff == 3'd6);
               end
               if (field_ff < FIELD_LAST) begin
                  field_in = field_ff + 1'b1;
               end
               count_in = '0;
            end else begin
               if (in_target && count_ff < 3'd6) begin
                  digits_in[count_ff] = char_code(byte_in);
               end
               if (count_ff < 3'd7) begin
                  count_in = count_ff + 3'd1;
               end
            end
         end
      end
   end

   // sentence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         gga_ff   <= 1'b1;
         rmc_ff   <= 1'b1;
         field_ff <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         gga_ff   <= gga_in;
         rmc_ff   <= rmc_in;
         field_ff <= field_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // captured character codes
   always_ff @(posedge clock) begin
      if (step) begin
         digits_ff <= digits_in;
      end
   end

endmodule

// ===== design/nte_clock_calc.sv =====
// ----------------------------------------------------------------------------
// nte_clock_calc: digit pairs to local time and date
// Reads the three character pairs, applies the zone offset as separate hour
// and minute parts with a minute carry, and wraps the hour into the day.
// ----------------------------------------------------------------------------
module nte_clock_calc (
   input  nte_pkg::nte_capture_type      capture,
   input  logic [nte_pkg::ZONE_W-1:0]    zone_index,
   output nte_pkg::nte_values_type       values
);

   logic [nte_pkg::ZONE_W-1:0] zone_sel;
   nte_pkg::nte_zone_type      zone;
   logic signed [7:0]          pair_a, pair_b, pair_c;
   logic signed [8:0]          min_sum;
   logic signed [2:0]          carry;
   logic [5:0]                 minute_fold;
   logic signed [8:0]          hour_sum;
   logic [7:0]                 hour_u;
   logic [7:0]                 hour_fold;

   // two character number as a string-to-integer read gives it
   function automatic logic signed [7:0] pair_value(input logic [nte_pkg::CODE_W-1:0] a,
                                                    input logic [nte_pkg::CODE_W-1:0] b);
      logic signed [7:0] v;
      logic [7:0]        ua;
      logic [7:0]        ub;
      ua = {4'b0, a};
      ub = {4'b0, b};
      v  = '0;
      if (a <= 4'd9) begin
         v = (b <= 4'd9) ? $signed(8'(ua * 8'd10 + ub)) : $signed(ua);
      end else if (b <= 4'd9) begin
         if (a == nte_pkg::CODE_SPACE || a == nte_pkg::CODE_PLUS) begin
            v = $signed(ub);
         end else if (a == nte_pkg::CODE_MINUS) begin
            v = -$signed(ub);
         end
      end
      return v;
   endfunction

   function automatic logic [6:0] clamp_date(input logic signed [7:0] v);
      return (v < 0) ? 7'd0 : 7'(v);
   endfunction

   // zone select, out of range picks the last entry
   always_comb begin
      zone_sel = (32'(zone_index) >= nte_pkg::ZONE_COUNT) ?
                 nte_pkg::ZONE_W'(nte_pkg::ZONE_COUNT - 1) : zone_index;
      zone     = nte_pkg::zone_offset(zone_sel);
   end

   assign pair_a = pair_value(capture.digits[0], capture.digits[1]);
   assign pair_b = pair_value(capture.digits[2], capture.digits[3]);
   assign pair_c = pair_value(capture.digits[4], capture.digits[5]);

   // minutes with carry into the hour, floor style
   always_comb begin
      min_sum = 9'(pair_b) + $signed({3'b0, zone.minute});
      if (min_sum < 0) begin
         carry       = -3'sd1;
         minute_fold = 6'(min_sum + 9'sd60);
      end else if (min_sum >= 9'sd120) begin
         carry       = 3'sd2;
         minute_fold = 6'(min_sum - 9'sd120);
      end else if (min_sum >= 9'sd60) begin
         carry       = 3'sd1;
         minute_fold = 6'(min_sum - 9'sd60);
      end else begin
         carry       = 3'sd0;
         minute_fold = 6'(min_sum);
      end
   end

   // hour of day, biased positive then wrapped by parallel compares
   always_comb begin
      hour_sum  = 9'(pair_a) + 9'(zone.hour) + 9'(carry) + 9'sd48;
      hour_u    = 8'(hour_sum);
      hour_fold = hour_u;
      for (int k = 1; k <= 6; k++) begin
         if (hour_u >= 8'(24 * k)) begin
            hour_fold = hour_u - 8'(24 * k);
         end
      end
   end

   // results; the time and the date use the same digit positions
   always_comb begin
      values.hour   = 5'(hour_fold);
      values.minute = minute_fold;
      if (pair_c < 0) begin
         values.second = 6'd0;
      end else if (pair_c > 8'sd59) begin
         values.second = 6'd59;
      end else begin
         values.second = 6'(pair_c);
      end
      values.day   = clamp_date(pair_a);
      values.month = clamp_date(pair_b);
      values.year  = clamp_date(pair_c);
   end

endmodule

// ===== design/nte_result_reg.sv =====
// ----------------------------------------------------------------------------
// nte_result_reg: held time and date with the output register
// Updates the held values when a sentence captures them and loads the
// report for every finished GGA or RMC sentence.
// ----------------------------------------------------------------------------
module nte_result_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  nte_pkg::nte_capture_type          capture,
   input  nte_pkg::nte_values_type           values,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic                              rsp_tuser,
   output logic [nte_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              free
);

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       kind_ff;
   logic [nte_pkg::RSP_DATA_W-1:0] data_ff, data_in;
   logic                       time_known_ff, time_known_in;
   logic                       date_known_ff, date_known_in;
   nte_pkg::nte_values_type    held_ff, held_in;

   assign free = !rsp_valid_ff || rsp_tready;

   // next held values
   always_comb begin
      held_in       = held_ff;
      time_known_in = time_known_ff;
      date_known_in = date_known_ff;
      if (capture.time_upd) begin
         held_in.hour   = values.hour;
         held_in.minute = values.minute;
         held_in.second = values.second;
         time_known_in  = 1'b1;
      end
      if (capture.date_upd) begin
         held_in.year  = values.year;
         held_in.month = values.month;
         held_in.day   = values.day;
         date_known_in = 1'b1;
      end
      data_in = {held_in.day, held_in.month, held_in.year, date_known_in,
                 held_in.second, held_in.minute, held_in.hour, time_known_in};
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (capture.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         time_known_ff <= 1'b0;
         date_known_ff <= 1'b0;
         held_ff       <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         time_known_ff <= time_known_in;
         date_known_ff <= date_known_in;
         held_ff       <= held_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (capture.emit) begin
         kind_ff <= capture.is_rmc;
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ===== design/nmea_time_date_extractor_top.sv =====
// ----------------------------------------------------------------------------
// nmea_time_date_extractor_top: NMEA GGA and RMC time and date extractor
// Takes receiver characters, tracks GGA and RMC sentences and reports the
// held local time and UTC date each time such a sentence ends.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload
//   req_     in         tdata[7:0] received character
//   rsp_     out        tuser sentence kind, tdata[39:0] held time and date
//   csr_     in         wdata[5:0] zone index, written when csr_we is high
//
// One character is taken every cycle while the output is free; the input register
// feeds the parser and clock arithmetic, which load the output register from the
// line feed held in the input register. Sustained rate is one character per cycle,
// set by the single parser update between the input and output registers.
// Reset is synchronous and active high; the zone index resets to UTC+0.
// A stalled result holds in the output register while one more character
// waits in the input register; req_tready stays high while the output is free.
// ----------------------------------------------------------------------------
module nmea_time_date_extractor_top (
   input  logic                              clock,
   input  logic                              reset,
   // request: rx_byte
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nte_pkg::BYTE_W-1:0]        req_tdata,
   // response tuser: sentence_kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tuser,
   // response tdata: time_known, local_hour, local_minute, utc_second,
   // date_known, year_in_century, month_value, day_value
   output logic [nte_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration: zone_index
   input  logic                              csr_we,
   input  logic [nte_pkg::ZONE_W-1:0]        csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   logic [nte_pkg::BYTE_W-1:0]    in_byte_ff;
   logic [nte_pkg::ZONE_W-1:0]    zone_ff;
   logic                          out_free;
   logic                          step;
   logic                          req_accept;
   nte_pkg::nte_capture_type      capture;
   nte_pkg::nte_values_type       values;

   // input register handshake
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign step       = in_valid_ff && out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         zone_ff     <= nte_pkg::ZONE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_we) begin
            zone_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   // sentence tracking
   nte_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .capture (capture)
   );

   // zone offset and digit decoding
   nte_clock_calc u_calc (
      .capture    (capture),
      .zone_index (zone_ff),
      .values     (values)
   );

   // held values and output register
   nte_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .capture    (capture),
      .values     (values),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .free       (out_free)
   );

   // a new result only follows a line feed in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff && in_byte_ff == nte_pkg::CHAR_LF))
      else $error("result appeared without a line feed");

   // an empty output register never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the output register empty");

   // reported time stays within a day
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:1] < 5'd24) && (rsp_tdata[11:6] < 6'd60) &&
                     (rsp_tdata[17:12] < 6'd60))
      else $error("reported time out of range");

endmodule
